/* hw/rtl/hdlp_pkg.sv */
// ----------------------------------------------------------------------------
// hdlp_pkg
// Types and constants shared by the hash dictionary front end, command queue
// and table engine.
// ----------------------------------------------------------------------------
package hdlp_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_W = 10;
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 10'd768;
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [2:0] OP_KEY    = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_ERGRP  = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] U_UNUSED = 2'd0;
  localparam logic [1:0] U_TOMB   = 2'd1;
  localparam logic [1:0] U_OCC    = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         key_byte;
    logic signed [31:0] group;
    logic signed [63:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [63:0] found_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] hash;
    logic [31:0] group;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic idle;
  } back_stat_t;

endpackage

/* hw/rtl/hdlp_front.sv */
// ----------------------------------------------------------------------------
// hdlp_front
// Accepts input transactions, folds key bytes into the running hash and
// forwards commands with their hash to the command queue.
// ----------------------------------------------------------------------------
module hdlp_front import hdlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  back_stat_t stat,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  logic [31:0] xb;
  logic        acc;
  logic        is_cmd;

  assign in_ready = stat.init_done && !q_full;
  assign acc      = in_valid && in_ready;
  assign is_cmd   = (in_data.opcode != OP_KEY) && (in_data.opcode <= OP_CLEAR);
  assign xb       = {{24{in_data.key_byte[7]}}, in_data.key_byte};

  assign push           = acc && is_cmd;
  assign push_cmd.op    = in_data.opcode;
  assign push_cmd.hash  = hash_r;
  assign push_cmd.group = in_data.group;
  assign push_cmd.value = in_data.new_value;

  always_comb begin
    hash_nxt = hash_r;
    if (acc) begin
      if (in_data.opcode == OP_KEY) begin
        if (in_data.key_byte != 8'd0) begin
          hash_nxt = (hash_r ^ xb) * HASH_PRIME;
        end
      end else if (is_cmd) begin
        hash_nxt = HASH_BASIS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

/* hw/rtl/hdlp_cmdq.sv */
// ----------------------------------------------------------------------------
// hdlp_cmdq
// Two-entry command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module hdlp_cmdq import hdlp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/hdlp_back.sv */
// ----------------------------------------------------------------------------
// hdlp_back
// Table engine: probes the slot memories one slot at a time, performs set,
// find, erase, group erase and clear, and holds the result register.
// ----------------------------------------------------------------------------
module hdlp_back import hdlp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MAX_W-1:0] max_entries,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             pop,
  output back_stat_t       stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > MAX_W) ? CW : MAX_W;
  localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
  localparam logic [63:0] RECIP_NUM = 64'd1 << (32 + IW);
  localparam logic [32:0] MREC = 33'(RECIP_NUM / 64'(CAPACITY) + 64'd1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_RD, S_EV, S_WRA, S_CLR, S_RESP
  } state_t;

  state_t      state_r;
  cmd_t        cmd_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] n_r;
  logic [IW-1:0] home_r;
  logic [IW-1:0] a_r;
  logic [64:0] prod_r;
  logic        mph_r;
  logic        ph2_r;
  logic [CW-1:0] cnt_r;
  logic        init_done_r;
  logic        res_found_r;
  logic [63:0] res_val_r;
  logic [1:0]  res_st_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [1:0]  usage_mem [CAPACITY];
  logic [31:0] group_mem [CAPACITY];
  logic [31:0] hash_mem  [CAPACITY];
  logic [63:0] value_mem [CAPACITY];
  logic [1:0]  u_q;
  logic [31:0] g_q;
  logic [31:0] h_q;
  logic [63:0] v_q;

  logic          we_u;
  logic [1:0]    wd_u;
  logic          we_meta;
  logic          we_v;
  logic [IW-1:0] wa;
  logic [1:0]    stop_lvl;
  logic          key_eq;
  logic          hit;
  logic          last;
  logic          full;
  logic [31:0]   quo;
  logic [31:0]   mod_h;
  logic [IW-1:0] idx_inc;
  logic          grp_hit;

  assign stop_lvl = (cmd_r.op == OP_SET && !ph2_r) ? U_TOMB : U_UNUSED;
  assign key_eq   = (g_q == cmd_r.group) && (h_q == cmd_r.hash);
  assign hit      = (u_q <= stop_lvl) || key_eq;
  assign last     = (n_r == LAST);
  assign full     = (CMPW'(cnt_r) >= CMPW'(max_entries));
  assign quo      = 32'(prod_r >> (32 + IW));
  assign mod_h    = cmd_r.hash - 32'(quo * 32'(CAPACITY));
  assign idx_inc  = (idx_r == LAST) ? '0 : idx_r + 1'b1;
  assign grp_hit  = (u_q == U_OCC) && (g_q == cmd_r.group);

  always_comb begin
    we_u    = 1'b0;
    wd_u    = U_UNUSED;
    we_meta = 1'b0;
    we_v    = 1'b0;
    wa      = idx_r;
    unique case (state_r)
      S_INIT, S_CLR: begin
        we_u = 1'b1;
      end
      S_WRA: begin
        wa      = a_r;
        we_u    = 1'b1;
        wd_u    = U_OCC;
        we_meta = 1'b1;
        we_v    = 1'b1;
      end
      S_EV: begin
        case (cmd_r.op)
          OP_SET: begin
            if (hit && u_q == U_OCC) begin
              if (ph2_r) begin
                we_u = 1'b1;
                wd_u = U_TOMB;
              end else begin
                we_v = 1'b1;
              end
            end
          end
          OP_ERASE: begin
            if (hit && u_q == U_OCC) begin
              we_u = 1'b1;
              wd_u = U_TOMB;
            end
          end
          OP_ERGRP: begin
            if (grp_hit) begin
              we_u = 1'b1;
              wd_u = U_TOMB;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_u) begin
      usage_mem[wa] <= wd_u;
    end
    u_q <= usage_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (we_meta) begin
      group_mem[wa] <= cmd_r.group;
      hash_mem[wa]  <= cmd_r.hash;
    end
    g_q <= group_mem[idx_r];
    h_q <= hash_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (we_v) begin
      value_mem[wa] <= cmd_r.value;
    end
    v_q <= value_mem[idx_r];
  end

  assign pop            = (state_r == S_IDLE) && q_valid;
  assign stat.init_done = init_done_r;
  assign stat.idle      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      n_r         <= '0;
      ph2_r       <= 1'b0;
      cnt_r       <= '0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          idx_r <= idx_inc;
          if (idx_r == LAST) begin
            init_done_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r       <= q_cmd;
            res_found_r <= 1'b0;
            res_val_r   <= '0;
            res_st_r    <= ST_DONE;
            ph2_r       <= 1'b0;
            n_r         <= '0;
            mph_r       <= 1'b0;
            if (q_cmd.op == OP_CLEAR) begin
              idx_r   <= '0;
              state_r <= S_CLR;
            end else if (q_cmd.op == OP_ERGRP) begin
              idx_r   <= '0;
              state_r <= S_RD;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (POW2) begin
            home_r  <= cmd_r.hash[IW-1:0];
            idx_r   <= cmd_r.hash[IW-1:0];
            state_r <= S_RD;
          end else if (!mph_r) begin
            prod_r <= 65'(cmd_r.hash) * 65'(MREC);
            mph_r  <= 1'b1;
          end else begin
            home_r  <= mod_h[IW-1:0];
            idx_r   <= mod_h[IW-1:0];
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          if (cmd_r.op == OP_ERGRP) begin
            if (grp_hit && cnt_r != '0) begin
              cnt_r <= cnt_r - 1'b1;
            end
            if (last) begin
              state_r <= S_RESP;
            end else begin
              n_r     <= n_r + 1'b1;
              idx_r   <= idx_inc;
              state_r <= S_RD;
            end
          end else if (!hit) begin
            if (last) begin
              if (cmd_r.op == OP_SET && ph2_r) begin
                if (full) begin
                  res_st_r <= ST_FULL;
                  state_r  <= S_RESP;
                end else begin
                  cnt_r   <= cnt_r + 1'b1;
                  state_r <= S_WRA;
                end
              end else begin
                res_st_r <= (cmd_r.op == OP_SET) ? ST_FULL : ST_ABSENT;
                state_r  <= S_RESP;
              end
            end else begin
              n_r     <= n_r + 1'b1;
              idx_r   <= idx_inc;
              state_r <= S_RD;
            end
          end else begin
            case (cmd_r.op)
              OP_SET: begin
                if (u_q == U_OCC) begin
                  state_r <= ph2_r ? S_WRA : S_RESP;
                end else if (!ph2_r && u_q == U_TOMB) begin
                  a_r     <= idx_r;
                  ph2_r   <= 1'b1;
                  n_r     <= '0;
                  idx_r   <= home_r;
                  state_r <= S_RD;
                end else begin
                  if (!ph2_r) begin
                    a_r <= idx_r;
                  end
                  if (full) begin
                    res_st_r <= ST_FULL;
                    state_r  <= S_RESP;
                  end else begin
                    cnt_r   <= cnt_r + 1'b1;
                    state_r <= S_WRA;
                  end
                end
              end
              OP_FIND: begin
                if (u_q == U_OCC) begin
                  res_found_r <= 1'b1;
                  res_val_r   <= v_q;
                end else begin
                  res_st_r <= ST_ABSENT;
                end
                state_r <= S_RESP;
              end
              default: begin
                if (u_q == U_OCC) begin
                  if (cnt_r != '0) begin
                    cnt_r <= cnt_r - 1'b1;
                  end
                end else begin
                  res_st_r <= ST_ABSENT;
                end
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_WRA: begin
          state_r <= S_RESP;
        end
        S_CLR: begin
          idx_r <= idx_inc;
          cnt_r <= '0;
          if (idx_r == LAST) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_r.found       <= res_found_r;
            out_r.found_value <= res_val_r;
            out_r.status      <= res_st_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/hash_dictionary_linear_probe.sv */
// ----------------------------------------------------------------------------
// hash_dictionary_linear_probe
// Fixed-capacity open-addressing dictionary keyed by a streamed FNV-1a hash.
// ----------------------------------------------------------------------------
// Nonzero key bytes are folded into the hash as accepted. A command waits in
// a two-entry queue; the engine takes it in S_IDLE, computes its home slot in
// S_MOD (with an extra multiply step if CAPACITY is not a power of two), reads
// and evaluates each probed slot in S_RD and S_EV, writes a new or moved entry
// in S_WRA and loads the result register in S_RESP. Group erase and clear
// sweep every slot. After reset in_ready is low while usage memory is cleared.
module hash_dictionary_linear_probe import hdlp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [MAX_W-1:0] cfg_wdata
);

  logic [MAX_W-1:0] max_entries_r;
  back_stat_t       stat;
  logic             q_full;
  logic             push;
  cmd_t             push_cmd;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      max_entries_r <= cfg_wdata;
    end
  end

  hdlp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hdlp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  hdlp_back #(.CAPACITY(CAPACITY)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_entries (max_entries_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during the clearing pass");

  a_ready_needs_init: assert property (@(posedge clk) in_ready |-> stat.init_done)
    else $error("input ready before the table was cleared");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> max_entries_r == $past(cfg_wdata))
    else $error("max_entries write lost");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.idle && stat.init_done)
    else $error("command taken while the engine was busy");

endmodule

/* tb/sv/hash_dictionary_linear_probe_tb.sv */
// ----------------------------------------------------------------------------
// hash_dictionary_linear_probe_tb
// Drives key bytes and dictionary commands into the table with random gaps
// and output stalls. A scoreboard keeps its own table, predicts the result
// of every command and compares each result transaction against it.
// ----------------------------------------------------------------------------
module hash_dictionary_linear_probe_tb;
  import hdlp_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  class dict_scoreboard;
    logic [9:0]  limit;
    logic [31:0] hash_acc;
    logic [1:0]  usage[CAP];
    logic [31:0] grp[CAP];
    logic [31:0] hsh[CAP];
    logic [63:0] val[CAP];
    int          count;
    out_item_t   pending[$];
    int          errors;

    function new();
      limit = MAX_ENTRIES_RST;
      hash_acc = HASH_BASIS;
      count = 0;
      errors = 0;
      foreach (usage[i]) usage[i] = U_UNUSED;
    endfunction

    function int probe(logic [31:0] h, logic [31:0] g, logic [1:0] stop);
      int i;
      i = h % CAP;
      for (int n = 0; n < CAP; n++) begin
        if (usage[i] <= stop) return i;
        if (grp[i] == g && hsh[i] == h) return i;
        i = (i + 1 >= CAP) ? 0 : i + 1;
      end
      return -1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [31:0] h, g, x;
      int a, b;
      h = hash_acc;
      g = it.group;
      r = '0;
      r.status = ST_DONE;
      if (it.opcode == OP_KEY) begin
        if (it.key_byte != 0) begin
          x = {{24{it.key_byte[7]}}, it.key_byte};
          hash_acc = (hash_acc ^ x) * HASH_PRIME;
        end
        return;
      end
      if (it.opcode > OP_CLEAR) return;
      hash_acc = HASH_BASIS;
      case (it.opcode)
        OP_SET: begin
          a = probe(h, g, U_TOMB);
          if (a < 0) r.status = ST_FULL;
          else if (usage[a] == U_OCC) val[a] = it.new_value;
          else begin
            b = -1;
            if (usage[a] == U_TOMB) begin
              b = probe(h, g, U_UNUSED);
              if (b >= 0 && usage[b] != U_OCC) b = -1;
            end
            if (b < 0 && count >= limit) r.status = ST_FULL;
            else begin
              if (b >= 0) usage[b] = U_TOMB;
              else count++;
              grp[a] = g;
              hsh[a] = h;
              usage[a] = U_OCC;
              val[a] = it.new_value;
            end
          end
        end
        OP_FIND: begin
          a = probe(h, g, U_UNUSED);
          if (a >= 0 && usage[a] == U_OCC) begin
            r.found = 1'b1;
            r.found_value = val[a];
          end else r.status = ST_ABSENT;
        end
        OP_ERASE: begin
          a = probe(h, g, U_UNUSED);
          if (a >= 0 && usage[a] == U_OCC) begin
            usage[a] = U_TOMB;
            if (count > 0) count--;
          end else r.status = ST_ABSENT;
        end
        OP_ERGRP: begin
          for (int i = 0; i < CAP; i++) begin
            if (usage[i] == U_OCC && grp[i] == g) begin
              usage[i] = U_TOMB;
              if (count > 0) count--;
            end
          end
        end
        default: begin
          foreach (usage[i]) usage[i] = U_UNUSED;
          count = 0;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, got.found);
        errors++;
      end
      if (got.found_value !== e.found_value) begin
        $error("found_value: expected %0d, actual %0d", e.found_value, got.found_value);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  dict_scoreboard sb = new();
  bit         hold_off = 1'b0;
  int         quiet_cycles = 0;
  logic [31:0] groups[4] = '{32'sd0, 32'sd7, 32'h8000_0000, 32'h7fff_ffff};

  always #5 clk = ~clk;

  hash_dictionary_linear_probe dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note_input(in_data);
    if (out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [2:0] op, input logic [7:0] kb,
                      input logic [31:0] g, input logic [63:0] v, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{opcode: op, key_byte: kb, group: g, new_value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_key(input int id, input bit gaps);
    int n;
    n = (id % 3) + 1;
    for (int i = 0; i < n; i++)
      send(OP_KEY, 8'(((id >> (i * 3)) & 8'h7) + 8'h7c), 32'h0, 64'h0, gaps);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (2 * CAP + 20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [9:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic random_phase(input int items, input int keys);
    int r, id;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      id = $urandom_range(0, keys - 1);
      if (r < 8) begin
        send(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
             {$urandom, $urandom}, 1);
      end else begin
        send_key(id, 1);
        r = $urandom_range(0, 99);
        send(r < 40 ? OP_SET : r < 75 ? OP_FIND : r < 96 ? OP_ERASE :
             r < 99 ? OP_ERGRP : OP_CLEAR, 8'h0, groups[id % 4],
             {$urandom, $urandom}, 1);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    send(OP_KEY, 8'hff, 32'h0, 64'h0, 0);
    send(OP_KEY, 8'h00, 32'h0, 64'h0, 0);
    send(OP_KEY, 8'h80, 32'h0, 64'h0, 0);
    send(OP_KEY, 8'h7f, 32'h0, 64'h0, 0);
    send(OP_SET, 8'h0, 32'h8000_0000, 64'h8000_0000_0000_0000, 0);
    send(OP_FIND, 8'h0, 32'h8000_0000, 64'h0, 0);
    send(OP_SET, 8'h0, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 0);
    send(OP_SET, 8'h0, 32'h7fff_ffff, 64'h1, 0);
    send(OP_FIND, 8'h0, 32'h7fff_ffff, 64'h0, 0);
    send(OP_FIND, 8'h0, 32'h1, 64'h0, 0);
    send(OP_ERASE, 8'h0, 32'h7fff_ffff, 64'h0, 0);
    send(OP_ERASE, 8'h0, 32'h7fff_ffff, 64'h0, 0);
    send(3'd6, 8'h55, 32'h1, 64'h0, 0);
    send(3'd7, 8'haa, 32'h1, 64'h0, 0);
    send(OP_SET, 8'h0, 32'h7fff_ffff, 64'h2, 0);
    send(OP_ERGRP, 8'h0, 32'h8000_0000, 64'h0, 0);
    send(OP_FIND, 8'h0, 32'h8000_0000, 64'h0, 0);
    send(OP_CLEAR, 8'h0, 32'h0, 64'h0, 0);
    drain();
    write_limit(10'd1);
    send(OP_SET, 8'h0, 32'h1, 64'h5, 0);
    send(OP_SET, 8'h0, 32'h2, 64'h6, 0);
    send(OP_SET, 8'h0, 32'h1, 64'h7, 0);
    send(OP_FIND, 8'h0, 32'h1, 64'h0, 0);
    send(OP_CLEAR, 8'h0, 32'h0, 64'h0, 0);
    drain();
    write_limit(10'd3);
    random_phase(120, 6);
    hold_off = 1'b1;
    random_phase(90, 12);
    drain();
    write_limit(10'd1023);
    random_phase(160, 40);
    drain();
    write_limit(10'd12);
    random_phase(120, 30);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* hash_dictionary_linear_probe.f */
hw/rtl/hdlp_pkg.sv
hw/rtl/hdlp_front.sv
hw/rtl/hdlp_cmdq.sv
hw/rtl/hdlp_back.sv
hw/rtl/hash_dictionary_linear_probe.sv
tb/sv/hash_dictionary_linear_probe_tb.sv
